### hdl/scsa_pkg.sv
// shared types, constants and register layout of the size class slot allocator
package scsa_pkg;

    localparam int CLASS_COUNT = 4;
    localparam int MAX_SLOTS   = 128;

    localparam int CLASS_W  = 2;
    localparam int SLOT_W   = 7;
    localparam int LIMIT_W  = 8;
    localparam int BYTES_W  = 16;
    localparam int REQ_W    = 32;
    localparam int CNT_W    = 32;
    localparam int STATUS_W = 3;

    localparam int APB_AW      = 5;
    localparam int APB_DW      = 32;
    localparam int REG_INDEX_W = 3;
    localparam int CFG_SEL_W   = $clog2(CLASS_COUNT);

    localparam logic [REG_INDEX_W-1:0] REG_SLOTS_BASE = 3'd4;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 120;

    localparam int GROUP_W     = 8;
    localparam int GROUPS      = MAX_SLOTS / GROUP_W;
    localparam int GROUP_CNT_W = $clog2(GROUP_W + 1);
    localparam int QUADS       = GROUPS / 4;
    localparam int QUAD_CNT_W  = GROUP_CNT_W + 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED    = 3'd0,
        ST_TOO_LARGE  = 3'd1,
        ST_EXHAUSTED  = 3'd2,
        ST_RELEASED   = 3'd3,
        ST_NOT_POOLED = 3'd4
    } status_t;

    localparam logic [CLASS_COUNT-1:0][BYTES_W-1:0] RESET_BYTES =
        {16'd16384, 16'd8192, 16'd4096, 16'd1024};
    localparam logic [CLASS_COUNT-1:0][LIMIT_W-1:0] RESET_SLOTS =
        {8'd10, 8'd25, 8'd50, 8'd100};

    typedef struct packed {
        logic [CLASS_COUNT-1:0][BYTES_W-1:0] bytes;
        logic [CLASS_COUNT-1:0][LIMIT_W-1:0] slots;
    } cfg_t;

    typedef struct packed {
        logic               op;
        logic [REQ_W-1:0]   bytes;
        logic [CLASS_W-1:0] cls;
        logic [SLOT_W-1:0]  slot;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [CLASS_W-1:0] cls;
        logic [SLOT_W-1:0]  slot;
        logic [CNT_W-1:0]   requests;
        logic [CNT_W-1:0]   hits;
        logic [CNT_W-1:0]   misses;
    } res_t;

endpackage

### hdl/scsa_cfg_regs.sv
// apb register file holding the per-class byte sizes and slot counts
module scsa_cfg_regs
    import scsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t                   cfg_reg;
    cfg_t                   cfg_next;
    logic [REG_INDEX_W-1:0] idx;
    logic [REG_INDEX_W-1:0] slot_idx;
    logic                   is_bytes;

    assign pready   = 1'b1;
    assign idx      = paddr[APB_AW-1:2];
    assign is_bytes = idx < REG_SLOTS_BASE;
    assign slot_idx = idx - REG_SLOTS_BASE;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite && pready)
        begin
            if (is_bytes)
                cfg_next.bytes[idx[CFG_SEL_W-1:0]] = pwdata[BYTES_W-1:0];
            else
                cfg_next.slots[slot_idx[CFG_SEL_W-1:0]] = pwdata[LIMIT_W-1:0];
        end
    end

    always_comb
    begin
        if (is_bytes)
            prdata = APB_DW'(cfg_reg.bytes[idx[CFG_SEL_W-1:0]]);
        else
            prdata = APB_DW'(cfg_reg.slots[slot_idx[CFG_SEL_W-1:0]]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bytes <= RESET_BYTES;
            cfg_reg.slots <= RESET_SLOTS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/scsa_alloc_core.sv
// class fit, first-free slot search, busy maps and per-class counters
module scsa_alloc_core
    import scsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  item_t                in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output res_t                 out_res,
    output logic [MAX_SLOTS-1:0] out_free
);

    logic [MAX_SLOTS-1:0] busy_reg     [CLASS_COUNT];
    logic [MAX_SLOTS-1:0] busy_next    [CLASS_COUNT];
    logic [CNT_W-1:0]     req_cnt_reg  [CLASS_COUNT];
    logic [CNT_W-1:0]     req_cnt_next [CLASS_COUNT];
    logic [CNT_W-1:0]     hit_cnt_reg  [CLASS_COUNT];
    logic [CNT_W-1:0]     hit_cnt_next [CLASS_COUNT];
    logic [CNT_W-1:0]     miss_cnt_reg [CLASS_COUNT];
    logic [CNT_W-1:0]     miss_cnt_next[CLASS_COUNT];

    logic                 valid_reg;
    logic                 valid_next;
    res_t                 res_reg;
    res_t                 res_next;
    logic [MAX_SLOTS-1:0] free_reg;
    logic [MAX_SLOTS-1:0] free_next;

    logic                 accept;
    logic                 found;
    logic [CLASS_W-1:0]   alloc_cls;
    logic [CLASS_W-1:0]   cls;
    logic                 class_ok;
    logic [LIMIT_W-1:0]   lim;
    logic [MAX_SLOTS-1:0] mask;
    logic [MAX_SLOTS-1:0] word;
    logic [MAX_SLOTS-1:0] word_new;
    logic [MAX_SLOTS-1:0] avail;
    logic                 any_free;
    logic [SLOT_W-1:0]    pos;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_free  = free_reg;

    // first class from zero upward whose buffer fits
    always_comb
    begin
        found     = 1'b0;
        alloc_cls = '0;
        for (int c = CLASS_COUNT - 1; c >= 0; c--)
        begin
            if (REQ_W'(cfg.bytes[c]) >= in_item.bytes)
            begin
                found     = 1'b1;
                alloc_cls = CLASS_W'(c);
            end
        end
    end

    assign cls      = in_item.op ? in_item.cls : alloc_cls;
    assign class_ok = !in_item.op || (int'(in_item.cls) < CLASS_COUNT);
    assign lim      = (cfg.slots[cls] > LIMIT_W'(MAX_SLOTS)) ? LIMIT_W'(MAX_SLOTS)
                                                             : cfg.slots[cls];
    assign word     = busy_reg[cls];

    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
            mask[i] = LIMIT_W'(i) < lim;
    end

    assign avail    = ~word & mask;
    assign any_free = |avail;

    // lowest free slot
    always_comb
    begin
        pos = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (avail[i])
                pos = SLOT_W'(i);
        end
    end

    always_comb
    begin
        busy_next     = busy_reg;
        req_cnt_next  = req_cnt_reg;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        res_next      = res_reg;
        free_next     = free_reg;
        word_new      = word;
        valid_next    = accept ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

        if (accept)
        begin
            res_next.cls  = cls;
            res_next.slot = '0;
            if (!in_item.op)
            begin
                if (found)
                begin
                    req_cnt_next[cls] = req_cnt_reg[cls] + CNT_W'(1);
                    if (any_free)
                    begin
                        word_new[pos]     = 1'b1;
                        hit_cnt_next[cls] = hit_cnt_reg[cls] + CNT_W'(1);
                        res_next.status   = ST_GRANTED;
                        res_next.slot     = pos;
                    end
                    else
                    begin
                        miss_cnt_next[cls] = miss_cnt_reg[cls] + CNT_W'(1);
                        res_next.status    = ST_EXHAUSTED;
                    end
                end
                else
                begin
                    res_next.status = ST_TOO_LARGE;
                    res_next.cls    = '0;
                end
            end
            else if (class_ok && mask[in_item.slot] && word[in_item.slot])
            begin
                word_new[in_item.slot] = 1'b0;
                res_next.status        = ST_RELEASED;
                res_next.slot          = in_item.slot;
            end
            else
            begin
                res_next.status = ST_NOT_POOLED;
            end

            busy_next[cls] = word_new;

            // too large or a class that does not exist reports zero stats
            if ((!in_item.op && !found) || !class_ok)
            begin
                res_next.requests = '0;
                res_next.hits     = '0;
                res_next.misses   = '0;
                free_next         = '0;
            end
            else
            begin
                res_next.requests = req_cnt_next[cls];
                res_next.hits     = hit_cnt_next[cls];
                res_next.misses   = miss_cnt_next[cls];
                free_next         = ~word_new & mask;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                busy_reg[c]     <= '0;
                req_cnt_reg[c]  <= '0;
                hit_cnt_reg[c]  <= '0;
                miss_cnt_reg[c] <= '0;
            end
        end
        else
        begin
            valid_reg    <= valid_next;
            busy_reg     <= busy_next;
            req_cnt_reg  <= req_cnt_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        free_reg <= free_next;
    end

endmodule

### hdl/scsa_free_count.sv
// two-stage population count of the free-slot vector, ending in the output register
module scsa_free_count
    import scsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  res_t                 in_res,
    input  logic [MAX_SLOTS-1:0] in_free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output res_t                 out_res,
    output logic [LIMIT_W-1:0]   out_free_count
);

    logic                                valid_b_reg;
    logic                                valid_b_next;
    res_t                                res_b_reg;
    logic [GROUPS-1:0][GROUP_CNT_W-1:0]  grp_b_reg;
    logic [GROUPS-1:0][GROUP_CNT_W-1:0]  grp_b_next;

    logic                                valid_c_reg;
    logic                                valid_c_next;
    res_t                                res_c_reg;
    logic [LIMIT_W-1:0]                  count_c_reg;
    logic [LIMIT_W-1:0]                  count_c_next;

    logic [QUADS-1:0][QUAD_CNT_W-1:0]    quad;
    logic                                ready_b;
    logic                                ready_c;
    logic                                load_b;
    logic                                load_c;

    assign ready_c  = !valid_c_reg || out_ready;
    assign ready_b  = !valid_b_reg || ready_c;
    assign in_ready = ready_b;
    assign load_b   = in_valid && ready_b;
    assign load_c   = valid_b_reg && ready_c;

    assign out_valid      = valid_c_reg;
    assign out_res        = res_c_reg;
    assign out_free_count = count_c_reg;

    // per-group bit counts
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_b_next[g] = '0;
            for (int b = 0; b < GROUP_W; b++)
                grp_b_next[g] = grp_b_next[g] + GROUP_CNT_W'(in_free[g * GROUP_W + b]);
        end
    end

    // groups summed in fours, then the fours summed
    always_comb
    begin
        for (int q = 0; q < QUADS; q++)
        begin
            quad[q] = '0;
            for (int k = 0; k < 4; k++)
                quad[q] = quad[q] + QUAD_CNT_W'(grp_b_reg[q * 4 + k]);
        end
        count_c_next = '0;
        for (int q = 0; q < QUADS; q++)
            count_c_next = count_c_next + LIMIT_W'(quad[q]);
    end

    assign valid_b_next = load_b ? 1'b1 : (ready_c ? 1'b0 : valid_b_reg);
    assign valid_c_next = load_c ? 1'b1 : (out_ready ? 1'b0 : valid_c_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else
        begin
            valid_b_reg <= valid_b_next;
            valid_c_reg <= valid_c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            res_b_reg <= in_res;
            grp_b_reg <= grp_b_next;
        end
        if (load_c)
        begin
            res_c_reg   <= res_b_reg;
            count_c_reg <= count_c_next;
        end
    end

endmodule

### hdl/size_class_slot_allocator.sv
// Size class slot allocator: four classes, each with a configured buffer size and
// slot count (APB registers at byte addresses 0x00-0x0c for sizes, 0x10-0x1c for
// slot counts). An allocate beat picks the first class that fits and grants its
// lowest free slot; a release beat frees a named busy slot. One input beat is
// taken every clock cycle while the output keeps up. The class compare, the
// first-free search over the 128-bit busy map and the counter update settle in
// the accept cycle, and two further register stages form the population count
// that yields the free-slot figure. Up to three beats are held inside, so the
// input stalls once three results wait on a stalled output. Busy maps and
// counters live in flip-flops cleared directly by reset, so the block is usable
// right after reset.
module size_class_slot_allocator
    import scsa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // request_bytes[31:0], release_class[33:32], release_slot[40:34], zero fill
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // operation[0]
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // result_class[1:0], result_slot[8:2], free_slots[16:9],
    // class_requests[48:17], class_hits[80:49], class_misses[112:81], zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [STATUS_W-1:0]    m_tuser,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    cfg_t                 cfg;
    item_t                item;
    logic                 core_valid;
    logic                 core_ready;
    res_t                 core_res;
    logic [MAX_SLOTS-1:0] core_free;
    res_t                 fc_res;
    logic [LIMIT_W-1:0]   fc_count;

    assign item.op    = s_tuser;
    assign item.bytes = s_tdata[31:0];
    assign item.cls   = s_tdata[33:32];
    assign item.slot  = s_tdata[40:34];

    scsa_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    scsa_alloc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .out_valid (core_valid),
        .out_ready (core_ready),
        .out_res   (core_res),
        .out_free  (core_free)
    );

    scsa_free_count u_count (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (core_valid),
        .in_ready       (core_ready),
        .in_res         (core_res),
        .in_free        (core_free),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_res        (fc_res),
        .out_free_count (fc_count)
    );

    assign m_tuser = fc_res.status;
    assign m_tdata = {7'b0, fc_res.misses, fc_res.hits, fc_res.requests,
                      fc_count, fc_res.slot, fc_res.cls};

`ifndef ASSERT_OFF
    // a granted slot must no longer show as free
    a_grant_busy: assert property (@(posedge clk) disable iff (!rst_n)
        core_valid && core_res.status == ST_GRANTED |-> !core_free[core_res.slot])
        else $error("granted slot still marked free");

    // a released slot must show as free
    a_release_free: assert property (@(posedge clk) disable iff (!rst_n)
        core_valid && core_res.status == ST_RELEASED |-> core_free[core_res.slot])
        else $error("released slot still marked busy");

    // input stalls only when the output side holds back
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // too large results carry no class, slot or statistics
    a_too_large_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_TOO_LARGE |-> m_tdata == '0)
        else $error("too large result carries nonzero fields");
`endif

endmodule
